@@ rtl/core/sdo_pkg.sv @@
// Shared types, widths and codes for the stepped dimmer with over-level alarm.
// Used by every module in rtl/core; no dependencies of its own.
package sdo_pkg;

    localparam int TIMER_BITS = 16;
    localparam int ADC_BITS   = 12;

    localparam int DATA_W  = 16;   // compare values and timer limits
    localparam int FS_W    = 12;   // adc_full_scale register
    localparam int DEB_W   = 8;    // debounce counter and limit
    localparam int MODE_W  = 3;
    localparam int CFG_A_W = 3;

    localparam int CMP_W  = (TIMER_BITS > DATA_W) ? TIMER_BITS : DATA_W;
    localparam int SMP_W  = (ADC_BITS > FS_W) ? ADC_BITS : FS_W;
    localparam int PROD_W = ADC_BITS + DATA_W;

    localparam int IN_W  = ((3 + ADC_BITS + 7) / 8) * 8;
    localparam int OUT_W = ((DATA_W + 2 + MODE_W + 7) / 8) * 8;

    // modes
    localparam logic [MODE_W-1:0] MODE_OFF  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_LOW  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_MID  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_FULL = 3'd3;
    localparam logic [MODE_W-1:0] MODE_ADC  = 3'd4;

    // register indexes
    localparam logic [CFG_A_W-1:0] REG_FULL_DUTY   = 3'd0;
    localparam logic [CFG_A_W-1:0] REG_DUTY_LOW    = 3'd1;
    localparam logic [CFG_A_W-1:0] REG_DUTY_MID    = 3'd2;
    localparam logic [CFG_A_W-1:0] REG_FULL_SCALE  = 3'd3;
    localparam logic [CFG_A_W-1:0] REG_ALARM_THR   = 3'd4;
    localparam logic [CFG_A_W-1:0] REG_ALARM_TICKS = 3'd5;
    localparam logic [CFG_A_W-1:0] REG_BLINK_TICKS = 3'd6;
    localparam logic [CFG_A_W-1:0] REG_DEB_TICKS   = 3'd7;

    typedef struct packed {
        logic [DATA_W-1:0] full_duty;
        logic [DATA_W-1:0] duty_low;
        logic [DATA_W-1:0] duty_mid;
        logic [FS_W-1:0]   adc_full_scale;
        logic [DATA_W-1:0] alarm_threshold;
        logic [DATA_W-1:0] alarm_ticks;
        logic [DATA_W-1:0] blink_ticks;
        logic [DEB_W-1:0]  debounce_ticks;
    } cfg_t;

    typedef struct packed {
        logic                button_edge;
        logic                button_low;
        logic                adc_valid;
        logic [ADC_BITS-1:0] adc_sample;
    } tick_t;

    typedef struct packed {
        logic [DATA_W-1:0] pwm_compare;
        logic              led_on;
        logic              adc_start;
        logic [MODE_W-1:0] mode;
    } result_t;

    typedef struct packed {
        logic              done;
        logic              sat;
        logic [DATA_W-1:0] quot;
    } div_res_t;

    // timer expiry: a zero limit behaves as one
    function automatic logic timer_hit(input logic [TIMER_BITS-1:0] cnt,
                                       input logic [DATA_W-1:0] limit);
        logic [DATA_W-1:0] lim;
        lim = (limit == '0) ? DATA_W'(1) : limit;
        return CMP_W'(cnt) >= CMP_W'(lim);
    endfunction

endpackage

@@ rtl/core/sdo_divider.sv @@
// Duty unit: one registered multiply, then a restoring divide,
// one quotient bit per cycle. Depends on sdo_pkg.
module sdo_divider (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [sdo_pkg::ADC_BITS-1:0] sample,
    input  logic [sdo_pkg::DATA_W-1:0]   period,
    input  logic [sdo_pkg::FS_W-1:0]     full_scale,
    output sdo_pkg::div_res_t            res
);
    import sdo_pkg::*;

    localparam int STEP_W = $clog2(DATA_W);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DATA_W - 1);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_INIT = 2'd1;
    localparam logic [1:0] PH_RUN  = 2'd2;

    logic [1:0]        phase_reg;
    logic [STEP_W-1:0] step_reg;
    logic              done_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [FS_W-1:0]   fs_reg;
    logic              sat_reg;
    logic [FS_W-1:0]   rem_reg;
    logic [DATA_W-1:0] quot_reg;

    logic [FS_W-1:0] fs_eff;
    logic [FS_W:0]   shifted;
    logic [FS_W:0]   diff;
    logic            fits;

    assign fs_eff  = (full_scale == '0) ? FS_W'(1) : full_scale;
    assign shifted = {rem_reg, quot_reg[DATA_W-1]};
    assign diff    = shifted - {1'b0, fs_reg};
    assign fits    = shifted >= {1'b0, fs_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            step_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (phase_reg)
                PH_IDLE:
                begin
                    if (start)
                        phase_reg <= PH_INIT;
                end
                PH_INIT:
                begin
                    step_reg  <= '0;
                    phase_reg <= PH_RUN;
                end
                PH_RUN:
                begin
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == LAST_STEP)
                    begin
                        phase_reg <= PH_IDLE;
                        done_reg  <= 1'b1;
                    end
                end
                default: phase_reg <= PH_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (phase_reg == PH_IDLE && start)
        begin
            prod_reg <= PROD_W'(sample) * PROD_W'(period);
            fs_reg   <= fs_eff;
            // sample at or above full scale always saturates at the period
            sat_reg  <= SMP_W'(sample) >= SMP_W'(fs_eff);
        end
        if (phase_reg == PH_INIT)
        begin
            // upper part is below full scale whenever the result does not saturate
            rem_reg  <= FS_W'(prod_reg >> DATA_W);
            quot_reg <= prod_reg[DATA_W-1:0];
        end
        else if (phase_reg == PH_RUN)
        begin
            rem_reg  <= fits ? diff[FS_W-1:0] : shifted[FS_W-1:0];
            quot_reg <= {quot_reg[DATA_W-2:0], fits};
        end
    end

    assign res.done = done_reg;
    assign res.sat  = sat_reg;
    assign res.quot = quot_reg;

endmodule

@@ rtl/core/sdo_mode_fsm.sv @@
// Tick state: debouncer, alarm/blink/stop timers and the mode machine.
// Commits one tick per apply strobe. Depends on sdo_pkg.
module sdo_mode_fsm (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       apply,
    input  sdo_pkg::tick_t             tick,
    input  sdo_pkg::cfg_t              cfg,
    input  logic                       div_sat,
    input  logic [sdo_pkg::DATA_W-1:0] div_quot,
    output sdo_pkg::result_t           result
);
    import sdo_pkg::*;

    logic [MODE_W-1:0]     mode_reg, mode_next;
    logic                  pend_reg, pend_next;
    logic [DEB_W-1:0]      deb_reg, deb_next;
    logic                  ae_reg, ae_next;
    logic [TIMER_BITS-1:0] ac_reg, ac_next;
    logic                  be_reg, be_next;
    logic [TIMER_BITS-1:0] bc_reg, bc_next;
    logic                  se_reg, se_next;
    logic [TIMER_BITS-1:0] sc_reg, sc_next;
    logic [DATA_W-1:0]     duty_reg, duty_next;
    logic                  led_reg, led_next;
    logic                  start_next;

    always_comb
    begin
        logic press, ev_alarm, ev_blink, ev_stop;
        mode_next  = mode_reg;
        duty_next  = duty_reg;
        led_next   = led_reg;
        start_next = 1'b0;

        pend_next = pend_reg | tick.button_edge;
        deb_next  = deb_reg;
        if (pend_next && deb_next != '1)
            deb_next = deb_next + 1'b1;
        press = 1'b0;
        // no pending check here: a zero limit confirms on level alone
        if (deb_next >= cfg.debounce_ticks && tick.button_low)
        begin
            pend_next = 1'b0;
            deb_next  = '0;
            press     = 1'b1;
        end

        ae_next  = ae_reg;
        ac_next  = ae_reg ? ac_reg + 1'b1 : '0;
        ev_alarm = timer_hit(ac_next, cfg.alarm_ticks);
        if (ev_alarm)
        begin
            ae_next = 1'b0;
            ac_next = '0;
        end
        be_next  = be_reg;
        bc_next  = be_reg ? bc_reg + 1'b1 : '0;
        ev_blink = timer_hit(bc_next, cfg.blink_ticks);
        if (ev_blink)
        begin
            be_next = 1'b0;
            bc_next = '0;
        end
        se_next  = se_reg;
        sc_next  = se_reg ? sc_reg + 1'b1 : '0;
        ev_stop  = timer_hit(sc_next, cfg.alarm_ticks);
        if (ev_stop)
        begin
            se_next = 1'b0;
            sc_next = '0;
        end

        // events in fixed order: sample, press, alarm, blink, stop
        if (tick.adc_valid && mode_next == MODE_ADC)
        begin
            duty_next = div_sat ? cfg.full_duty : div_quot;
            if (duty_next >= cfg.alarm_threshold)
                ae_next = 1'b1;
            else
            begin
                ae_next = 1'b0;
                be_next = 1'b0;
                se_next = 1'b0;
            end
            start_next = 1'b1;
        end

        if (press)
        begin
            case (mode_next)
                MODE_OFF:
                begin
                    duty_next = cfg.duty_low;
                    mode_next = MODE_LOW;
                end
                MODE_LOW:
                begin
                    duty_next = cfg.duty_mid;
                    mode_next = MODE_MID;
                end
                MODE_MID:
                begin
                    duty_next = cfg.full_duty;
                    ae_next   = 1'b1;
                    mode_next = MODE_FULL;
                end
                MODE_FULL:
                begin
                    led_next   = 1'b0;
                    ae_next    = 1'b0;
                    be_next    = 1'b0;
                    se_next    = 1'b0;
                    mode_next  = MODE_ADC;
                    start_next = 1'b1;
                end
                MODE_ADC:
                begin
                    led_next  = 1'b0;
                    duty_next = '0;
                    mode_next = MODE_OFF;
                end
                default: ;
            endcase
        end

        if (ev_alarm && (mode_next inside {MODE_FULL, MODE_ADC}))
        begin
            duty_next = '0;
            led_next  = ~led_next;
            be_next   = 1'b1;
            se_next   = 1'b1;
        end

        if (ev_blink && (mode_next inside {MODE_FULL, MODE_ADC}))
        begin
            led_next = ~led_next;
            be_next  = 1'b1;
        end

        if (ev_stop)
        begin
            if (mode_next == MODE_FULL)
            begin
                duty_next = cfg.full_duty;
                led_next  = 1'b0;
                be_next   = 1'b0;
                ae_next   = 1'b1;
            end
            else if (mode_next == MODE_ADC)
            begin
                led_next   = 1'b0;
                be_next    = 1'b0;
                start_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_OFF;
            pend_reg <= 1'b0;
            deb_reg  <= '0;
            ae_reg   <= 1'b0;
            ac_reg   <= '0;
            be_reg   <= 1'b0;
            bc_reg   <= '0;
            se_reg   <= 1'b0;
            sc_reg   <= '0;
            duty_reg <= '0;
            led_reg  <= 1'b0;
        end
        else if (apply)
        begin
            mode_reg <= mode_next;
            pend_reg <= pend_next;
            deb_reg  <= deb_next;
            ae_reg   <= ae_next;
            ac_reg   <= ac_next;
            be_reg   <= be_next;
            bc_reg   <= bc_next;
            se_reg   <= se_next;
            sc_reg   <= sc_next;
            duty_reg <= duty_next;
            led_reg  <= led_next;
        end
    end

    assign result.pwm_compare = duty_next;
    assign result.led_on      = led_next;
    assign result.adc_start   = start_next;
    assign result.mode        = mode_next;

endmodule

@@ rtl/core/stepped_dimmer_with_overlevel_alarm_top.sv @@
// Top level of the stepped dimmer with over-level alarm: stream ports,
// config registers, sequencer and output register. Uses sdo_pkg,
// sdo_divider and sdo_mode_fsm.
//
// Each s_axis beat is one millisecond tick (button edge, button level, ADC
// result) and yields exactly one m_axis beat: compare value, LED level, ADC
// start pulse and mode. Registers are written through cfg_wen/cfg_addr/
// cfg_wdata, one per cycle; the user must write them only while no tick is in
// flight (the block does not enforce this). The sample times period product
// is registered as the beat is accepted; the divider then loads, runs the
// restoring divide one quotient bit per step and signals done, and the
// sequencer commits the tick once the output register is free.
// s_axis_tready is high only while the sequencer is idle, from the cycle
// after the commit, so no new tick is taken until the last one is committed.
// Reset: rst_n clears the mode (off), all timers, the LED and the output
// valid, and loads the register defaults.
// Stalls: the output register holds a finished beat while m_axis_tready is
// low; the next tick is still accepted and computed, and waits at commit
// until the output register is free.
module stepped_dimmer_with_overlevel_alarm_top (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // button_edge, button_low, adc_valid, adc_sample, zero fill
    input  logic [sdo_pkg::IN_W-1:0]    s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // pwm_compare, led_on, adc_start, mode, zero fill
    output logic [sdo_pkg::OUT_W-1:0]   m_axis_tdata,
    input  logic                        cfg_wen,
    input  logic [sdo_pkg::CFG_A_W-1:0] cfg_addr,
    input  logic [sdo_pkg::DATA_W-1:0]  cfg_wdata
);
    import sdo_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CALC  = 2'd1;
    localparam logic [1:0] ST_APPLY = 2'd2;

    logic [1:0] st_reg, st_next;
    logic       ovalid_reg, ovalid_next;
    result_t    obeat_reg;
    tick_t      tick_reg;
    cfg_t       cfg_reg;

    tick_t      tick_in;
    logic       in_acc;
    logic       apply;
    div_res_t   div_res;
    result_t    result;

    assign tick_in.button_edge = s_axis_tdata[0];
    assign tick_in.button_low  = s_axis_tdata[1];
    assign tick_in.adc_valid   = s_axis_tdata[2];
    assign tick_in.adc_sample  = s_axis_tdata[ADC_BITS+2:3];

    assign s_axis_tready = (st_reg == ST_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign apply         = (st_reg == ST_APPLY) && (!ovalid_reg || m_axis_tready);

    sdo_divider u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (in_acc),
        .sample     (tick_in.adc_sample),
        .period     (cfg_reg.full_duty),
        .full_scale (cfg_reg.adc_full_scale),
        .res        (div_res)
    );

    sdo_mode_fsm u_fsm (
        .clk      (clk),
        .rst_n    (rst_n),
        .apply    (apply),
        .tick     (tick_reg),
        .cfg      (cfg_reg),
        .div_sat  (div_res.sat),
        .div_quot (div_res.quot),
        .result   (result)
    );

    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            ST_IDLE:
            begin
                if (in_acc)
                    st_next = ST_CALC;
            end
            ST_CALC:
            begin
                if (div_res.done)
                    st_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                if (apply)
                    st_next = ST_IDLE;
            end
            default: st_next = ST_IDLE;
        endcase

        ovalid_next = ovalid_reg;
        if (m_axis_tvalid && m_axis_tready)
            ovalid_next = 1'b0;
        if (apply)
            ovalid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= ST_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            st_reg     <= st_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
            tick_reg <= tick_in;
        if (apply)
            obeat_reg <= result;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.full_duty       <= DATA_W'(1999);
            cfg_reg.duty_low        <= DATA_W'(600);
            cfg_reg.duty_mid        <= DATA_W'(1399);
            cfg_reg.adc_full_scale  <= FS_W'(4050);
            cfg_reg.alarm_threshold <= DATA_W'(1580);
            cfg_reg.alarm_ticks     <= DATA_W'(5000);
            cfg_reg.blink_ticks     <= DATA_W'(300);
            cfg_reg.debounce_ticks  <= DEB_W'(10);
        end
        else if (cfg_wen)
        begin
            case (cfg_addr)
                REG_FULL_DUTY:   cfg_reg.full_duty       <= cfg_wdata;
                REG_DUTY_LOW:    cfg_reg.duty_low        <= cfg_wdata;
                REG_DUTY_MID:    cfg_reg.duty_mid        <= cfg_wdata;
                REG_FULL_SCALE:  cfg_reg.adc_full_scale  <= cfg_wdata[FS_W-1:0];
                REG_ALARM_THR:   cfg_reg.alarm_threshold <= cfg_wdata;
                REG_ALARM_TICKS: cfg_reg.alarm_ticks     <= cfg_wdata;
                REG_BLINK_TICKS: cfg_reg.blink_ticks     <= cfg_wdata;
                REG_DEB_TICKS:   cfg_reg.debounce_ticks  <= cfg_wdata[DEB_W-1:0];
                default: ;
            endcase
        end
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = OUT_W'({obeat_reg.mode, obeat_reg.adc_start,
                                   obeat_reg.led_on, obeat_reg.pwm_compare});

    // a beat taken in moves the sequencer into the divide
    a_accept_calc: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> st_reg == ST_CALC)
        else $error("tick accepted but sequencer not computing");

    // the divider only finishes for a tick in flight
    a_done_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
        div_res.done |-> st_reg == ST_CALC)
        else $error("divider result with no tick in flight");

    // a commit always leaves a valid beat in the output register
    a_apply_valid: assert property (@(posedge clk) disable iff (!rst_n)
        apply |=> m_axis_tvalid && st_reg == ST_IDLE)
        else $error("commit did not produce an output beat");

    // mode field stays within its codes
    a_mode_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> obeat_reg.mode <= MODE_ADC)
        else $error("mode out of range");

endmodule

@@ test/dimmer_checker.sv @@
`timescale 1ns / 100ps
// Checker for the stepped dimmer: watches the tick, result and register ports,
// keeps its own copy of the dimmer state and compares every result beat.
// Depends on sdo_pkg for widths, mode codes and register indexes.
module dimmer_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    input  logic                        s_axis_tready,
    input  logic [sdo_pkg::IN_W-1:0]    s_axis_tdata,
    input  logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    input  logic [sdo_pkg::OUT_W-1:0]   m_axis_tdata,
    input  logic                        cfg_wen,
    input  logic [sdo_pkg::CFG_A_W-1:0] cfg_addr,
    input  logic [sdo_pkg::DATA_W-1:0]  cfg_wdata,
    output int                          errors,
    output int                          outstanding
);
    import sdo_pkg::*;

    cfg_t regs;

    logic [MODE_W-1:0] mode_q;
    logic              press_pend;
    logic [DEB_W-1:0]  deb_cnt;
    logic              alarm_on, blink_on, stop_on;
    logic [15:0]       alarm_cnt, blink_cnt, stop_cnt;
    logic [15:0]       duty;
    logic              led;
    logic              start;

    logic [OUT_W-1:0]  due_outputs[$];
    logic [OUT_W-1:0]  want;

    initial errors = 0;

    // {fired, next count}; a zero limit counts as one
    function automatic logic [16:0] timer_step(input logic on, input logic [15:0] cnt,
                                               input logic [15:0] limit);
        logic [15:0] lim;
        logic [15:0] nxt;
        lim = (limit == 16'd0) ? 16'd1 : limit;
        nxt = on ? cnt + 16'd1 : 16'd0;
        if (nxt >= lim)
            return {1'b1, 16'd0};
        return {1'b0, nxt};
    endfunction

    task automatic advance_dimmer(input logic [IN_W-1:0] beat, output logic [OUT_W-1:0] res);
        logic        btn_edge, btn_low, smp_valid, press;
        logic [11:0] smp;
        logic [16:0] t_alarm, t_blink, t_stop;
        logic [31:0] prod, fs, quo;
        btn_edge  = beat[0];
        btn_low   = beat[1];
        smp_valid = beat[2];
        smp       = beat[14:3];
        start     = 1'b0;
        press     = 1'b0;

        if (btn_edge)
            press_pend = 1'b1;
        if (press_pend && deb_cnt != 8'hFF)
            deb_cnt = deb_cnt + 8'd1;
        if (deb_cnt >= regs.debounce_ticks && btn_low)
        begin
            press_pend = 1'b0;
            deb_cnt    = '0;
            press      = 1'b1;
        end

        // all timers see the state from the start of the tick
        t_alarm = timer_step(alarm_on, alarm_cnt, regs.alarm_ticks);
        t_blink = timer_step(blink_on, blink_cnt, regs.blink_ticks);
        t_stop  = timer_step(stop_on, stop_cnt, regs.alarm_ticks);
        alarm_cnt = t_alarm[15:0];
        blink_cnt = t_blink[15:0];
        stop_cnt  = t_stop[15:0];
        if (t_alarm[16]) alarm_on = 1'b0;
        if (t_blink[16]) blink_on = 1'b0;
        if (t_stop[16])  stop_on  = 1'b0;

        if (smp_valid && mode_q == MODE_ADC)
        begin
            fs   = (regs.adc_full_scale == '0) ? 32'd1 : 32'(regs.adc_full_scale);
            prod = 32'(smp) * 32'(regs.full_duty);
            quo  = prod / fs;
            if (quo > 32'(regs.full_duty))
                quo = 32'(regs.full_duty);
            duty = quo[15:0];
            if (duty >= regs.alarm_threshold)
                alarm_on = 1'b1;
            else
            begin
                alarm_on = 1'b0;
                blink_on = 1'b0;
                stop_on  = 1'b0;
            end
            start = 1'b1;
        end

        if (press)
        begin
            case (mode_q)
                MODE_OFF:
                begin
                    duty   = regs.duty_low;
                    mode_q = MODE_LOW;
                end
                MODE_LOW:
                begin
                    duty   = regs.duty_mid;
                    mode_q = MODE_MID;
                end
                MODE_MID:
                begin
                    duty     = regs.full_duty;
                    alarm_on = 1'b1;
                    mode_q   = MODE_FULL;
                end
                MODE_FULL:
                begin
                    led      = 1'b0;
                    alarm_on = 1'b0;
                    blink_on = 1'b0;
                    stop_on  = 1'b0;
                    mode_q   = MODE_ADC;
                    start    = 1'b1;
                end
                MODE_ADC:
                begin
                    led    = 1'b0;
                    duty   = '0;
                    mode_q = MODE_OFF;
                end
                default: ;
            endcase
        end

        if (t_alarm[16] && (mode_q == MODE_FULL || mode_q == MODE_ADC))
        begin
            duty     = '0;
            led      = !led;
            blink_on = 1'b1;
            stop_on  = 1'b1;
        end

        if (t_blink[16] && (mode_q == MODE_FULL || mode_q == MODE_ADC))
        begin
            led      = !led;
            blink_on = 1'b1;
        end

        if (t_stop[16])
        begin
            if (mode_q == MODE_FULL)
            begin
                duty     = regs.full_duty;
                led      = 1'b0;
                blink_on = 1'b0;
                alarm_on = 1'b1;
            end
            else if (mode_q == MODE_ADC)
            begin
                led      = 1'b0;
                blink_on = 1'b0;
                start    = 1'b1;
            end
        end

        res = {3'b000, mode_q, start, led, duty};
    endtask

    task automatic check_field(input string name, input logic [15:0] want_v,
                               input logic [15:0] got_v);
        if (got_v !== want_v)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want_v, got_v);
            errors++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs.full_duty       = 16'd1999;
            regs.duty_low        = 16'd600;
            regs.duty_mid        = 16'd1399;
            regs.adc_full_scale  = 12'd4050;
            regs.alarm_threshold = 16'd1580;
            regs.alarm_ticks     = 16'd5000;
            regs.blink_ticks     = 16'd300;
            regs.debounce_ticks  = 8'd10;
            mode_q     = MODE_OFF;
            press_pend = 1'b0;
            deb_cnt    = '0;
            alarm_on   = 1'b0;
            blink_on   = 1'b0;
            stop_on    = 1'b0;
            alarm_cnt  = '0;
            blink_cnt  = '0;
            stop_cnt   = '0;
            duty       = '0;
            led        = 1'b0;
            start      = 1'b0;
            due_outputs.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg_wen)
            begin
                case (cfg_addr)
                    REG_FULL_DUTY:   regs.full_duty       = cfg_wdata;
                    REG_DUTY_LOW:    regs.duty_low        = cfg_wdata;
                    REG_DUTY_MID:    regs.duty_mid        = cfg_wdata;
                    REG_FULL_SCALE:  regs.adc_full_scale  = cfg_wdata[FS_W-1:0];
                    REG_ALARM_THR:   regs.alarm_threshold = cfg_wdata;
                    REG_ALARM_TICKS: regs.alarm_ticks     = cfg_wdata;
                    REG_BLINK_TICKS: regs.blink_ticks     = cfg_wdata;
                    REG_DEB_TICKS:   regs.debounce_ticks  = cfg_wdata[DEB_W-1:0];
                    default: ;
                endcase
            end

            if (s_axis_tvalid && s_axis_tready)
            begin
                advance_dimmer(s_axis_tdata, want);
                due_outputs.push_back(want);
            end

            if (m_axis_tvalid && m_axis_tready)
            begin
                if (due_outputs.size() == 0)
                begin
                    $display("%0t: result beat expected none, got %h", $time, m_axis_tdata);
                    errors++;
                end
                else
                begin
                    want = due_outputs.pop_front();
                    check_field("pwm_compare", want[15:0], m_axis_tdata[15:0]);
                    check_field("led_on", 16'(want[16]), 16'(m_axis_tdata[16]));
                    check_field("adc_start", 16'(want[17]), 16'(m_axis_tdata[17]));
                    check_field("mode", 16'(want[20:18]), 16'(m_axis_tdata[20:18]));
                end
            end

            outstanding <= due_outputs.size();
        end
    end

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 100ps
// Top of the dimmer testbench: clock, reset, tick stimulus, register phases
// and the verdict. Depends on sdo_pkg, the dimmer top and dimmer_checker.
module testbench;
    import sdo_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic               s_axis_tready;
    // button_edge, button_low, adc_valid, adc_sample, zero fill
    logic [IN_W-1:0]    s_axis_tdata = '0;
    logic               m_axis_tvalid;
    logic               m_axis_tready = 1'b0;
    // pwm_compare, led_on, adc_start, mode, zero fill
    logic [OUT_W-1:0]   m_axis_tdata;
    logic               cfg_wen = 1'b0;
    logic [CFG_A_W-1:0] cfg_addr = REG_FULL_DUTY;
    logic [DATA_W-1:0]  cfg_wdata = '0;

    int fail_count;
    int outstanding;
    int cycle_count = 0;
    int stall_left = 0;
    int hold_low = 0;
    bit calm = 1'b0;

    stepped_dimmer_with_overlevel_alarm_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wen       (cfg_wen),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    dimmer_checker u_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wen       (cfg_wen),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .errors        (fail_count),
        .outstanding   (outstanding)
    );

    always #2 clk = ~clk;

    // mostly none, often short, now and then long
    function automatic int rand_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [IN_W-1:0] tick_beat(input bit btn_edge, input bit btn_low,
                                                  input bit smp_valid, input logic [11:0] smp);
        return {1'b0, smp, smp_valid, btn_low, btn_edge};
    endfunction

    // button held low for a few ticks after most edges, some bounce and noise
    function automatic logic [IN_W-1:0] random_tick();
        bit          btn_edge, btn_low, smp_valid;
        logic [11:0] smp;
        int          r;
        btn_edge = ($urandom_range(0, 99) < 8);
        if (btn_edge && $urandom_range(0, 3) != 0)
            hold_low = $urandom_range(1, 7);
        btn_low = (hold_low > 0) || ($urandom_range(0, 99) < 5);
        if (hold_low > 0)
            hold_low--;
        smp_valid = ($urandom_range(0, 99) < 35);
        r = $urandom_range(0, 9);
        if (r == 0)
            smp = 12'd0;
        else if (r == 1)
            smp = 12'hFFF;
        else
            smp = 12'($urandom_range(0, 4095));
        return tick_beat(btn_edge, btn_low, smp_valid, smp);
    endfunction

    task automatic send_tick(input logic [IN_W-1:0] beat);
        int gap;
        gap = calm ? 0 : rand_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= beat;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_A_W-1:0] idx, input logic [DATA_W-1:0] val);
        cfg_wen   <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
    endtask

    task automatic load_regs(input logic [15:0] period, input logic [15:0] lo,
                             input logic [15:0] mid, input logic [15:0] fs,
                             input logic [15:0] thr, input logic [15:0] al,
                             input logic [15:0] bl, input logic [15:0] deb);
        write_reg(REG_FULL_DUTY, period);
        write_reg(REG_DUTY_LOW, lo);
        write_reg(REG_DUTY_MID, mid);
        write_reg(REG_FULL_SCALE, fs);
        write_reg(REG_ALARM_THR, thr);
        write_reg(REG_ALARM_TICKS, al);
        write_reg(REG_BLINK_TICKS, bl);
        write_reg(REG_DEB_TICKS, deb);
        cfg_wen <= 1'b0;
    endtask

    // drop the last beat, let the checker's count cover the last accepted tick,
    // then wait until no result is outstanding
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            if (!calm)
                stall_left = rand_gap();
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        logic [15:0] period;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: idle tick, bounce with no press, then a ten tick debounce
        send_tick(tick_beat(1'b0, 1'b0, 1'b0, 12'd0));
        send_tick(tick_beat(1'b1, 1'b0, 1'b1, 12'hFFF));
        repeat (9) send_tick(tick_beat(1'b0, 1'b1, 1'b0, 12'd0));

        wait_drained();
        load_regs(16'd1999, 16'd600, 16'd1399, 16'd4050, 16'd1580, 16'd4, 16'd1, 16'd1);
        // walk the modes; in full the alarm fires, blinks and is stopped
        repeat (3) send_tick(tick_beat(1'b1, 1'b1, 1'b0, 12'd0));
        repeat (8) send_tick(tick_beat(1'b0, 1'b0, 1'b1, 12'hFFF));
        send_tick(tick_beat(1'b1, 1'b1, 1'b0, 12'd0));
        send_tick(tick_beat(1'b0, 1'b0, 1'b1, 12'hFFF));
        send_tick(tick_beat(1'b0, 1'b0, 1'b1, 12'd0));
        send_tick(tick_beat(1'b0, 1'b0, 1'b1, 12'd2048));
        // sample and press in one tick: sample first, then back to off
        send_tick(tick_beat(1'b1, 1'b1, 1'b1, 12'hFFF));

        for (int ph = 0; ph < 8; ph++)
        begin
            wait_drained();
            calm = (ph % 3 == 1);
            period = 16'($urandom_range(0, 65535));
            case (ph)
                0: load_regs(16'd1999, 16'd600, 16'd1399, 16'd4050, 16'd1580,
                             16'($urandom_range(2, 12)), 16'($urandom_range(1, 4)),
                             16'($urandom_range(1, 4)));
                1: load_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                             16'hFFFF, 16'hFFFF, 16'hFFFF);
                2: load_regs(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
                3: load_regs(period, 16'($urandom_range(0, 65535)),
                             16'($urandom_range(0, 65535)), 16'd1,
                             16'($urandom_range(0, period)), 16'($urandom_range(1, 6)),
                             16'($urandom_range(1, 3)), 16'($urandom_range(1, 3)));
                default: load_regs(period, 16'($urandom_range(0, 65535)),
                                   16'($urandom_range(0, 65535)),
                                   16'($urandom_range(0, 65535)),
                                   16'($urandom_range(0, period)),
                                   16'($urandom_range(1, 20)), 16'($urandom_range(1, 6)),
                                   {8'($urandom_range(0, 255)), 8'($urandom_range(1, 6))});
            endcase
            repeat (55) send_tick(random_tick());
        end

        wait_drained();
        if (fail_count == 0 && outstanding == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/sdo_pkg.sv
rtl/core/sdo_divider.sv
rtl/core/sdo_mode_fsm.sv
rtl/core/stepped_dimmer_with_overlevel_alarm_top.sv
test/dimmer_checker.sv
test/testbench.sv
